/* design/npc_pkg.sv */
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color unit.
// ----------------------------------------------------------------------------
package npc_pkg;

  // Palette geometry. Entries 1 to PALETTE_SIZE-1 are searched.
  localparam int PALETTE_SIZE = 256;
  localparam int STORE_DEPTH  = 256;
  localparam int IDX_W        = 8;
  localparam int CHAN_W       = 8;
  localparam int COLOR_W      = 3 * CHAN_W;
  localparam int SQ_W         = 2 * CHAN_W;
  localparam int DIST_W       = 18;

  // Largest possible squared distance, three channels of 255 squared.
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(195075);

  // Last index that a search visits.
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_SIZE - 1);

  // Item kind carried in tuser.
  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } state_t;

  // Control from the sequencer to the distance datapath and the palette RAM.
  typedef struct packed {
    logic             start;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } npc_ctl_t;

endpackage

/* design/npc_palette_ram.sv */
// ----------------------------------------------------------------------------
// npc_palette_ram
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module npc_palette_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [npc_pkg::IDX_W-1:0]   wr_addr,
  input  logic [npc_pkg::COLOR_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [npc_pkg::IDX_W-1:0]   rd_addr,
  output logic [npc_pkg::COLOR_W-1:0] rd_data
);
  import npc_pkg::*;

  logic [COLOR_W-1:0] mem [STORE_DEPTH];
  logic [COLOR_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/npc_dist_min.sv */
// ----------------------------------------------------------------------------
// npc_dist_min
// Distance pipeline: squares the channel differences of each palette entry
// against the held query color, then keeps the running minimum.
// ----------------------------------------------------------------------------
module npc_dist_min (
  input  logic                        clk,
  input  logic                        rst_n,
  input  npc_pkg::npc_ctl_t           ctl,
  input  logic [npc_pkg::COLOR_W-1:0] query_color,
  input  logic [npc_pkg::COLOR_W-1:0] rd_data,
  output logic                        busy,
  output logic [npc_pkg::IDX_W-1:0]   best_idx,
  output logic [npc_pkg::DIST_W-1:0]  best_dist
);
  import npc_pkg::*;

  logic [COLOR_W-1:0] query_r;
  logic               v1_r;
  logic [IDX_W-1:0]   idx1_r;
  logic               v2_r;
  logic [IDX_W-1:0]   idx2_r;
  logic [SQ_W-1:0]    sq_r_r, sq_g_r, sq_b_r;
  logic [SQ_W-1:0]    sq_r_nxt, sq_g_nxt, sq_b_nxt;
  logic [DIST_W-1:0]  dist_sum;
  logic [IDX_W-1:0]   best_idx_r;
  logic [DIST_W-1:0]  best_dist_r;

  // Absolute difference of one channel, squared.
  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // Hold the query color for the whole search.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      query_r <= query_color;
    end
  end

  // Valid bits track reads through the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.rd_en;
      v2_r <= v1_r;
    end
  end

  // Stage one: read data arrives, channel squares are formed.
  always_comb begin
    sq_r_nxt = sq_diff(rd_data[23:16], query_r[23:16]);
    sq_g_nxt = sq_diff(rd_data[15:8],  query_r[15:8]);
    sq_b_nxt = sq_diff(rd_data[7:0],   query_r[7:0]);
  end

  always_ff @(posedge clk) begin
    idx1_r <= ctl.rd_idx;
    idx2_r <= idx1_r;
    sq_r_r <= sq_r_nxt;
    sq_g_r <= sq_g_nxt;
    sq_b_r <= sq_b_nxt;
  end

  // Stage two: sum the squares and keep the strict minimum.
  assign dist_sum = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);

  always_ff @(posedge clk) begin
    // The first searched entry always seeds the minimum.
    if (v2_r && ((idx2_r == IDX_W'(1)) || (dist_sum < best_dist_r))) begin
      best_idx_r  <= idx2_r;
      best_dist_r <= dist_sum;
    end
  end

  assign busy      = v1_r | v2_r;
  assign best_idx  = best_idx_r;
  assign best_dist = best_dist_r;

endmodule

/* design/npc_search_ctrl.sv */
// ----------------------------------------------------------------------------
// npc_search_ctrl
// Search sequencer: accepts items, walks the palette addresses of a query
// and signals when the minimum is final.
// ----------------------------------------------------------------------------
module npc_search_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  npc_pkg::func_t    in_func,
  input  logic              dp_busy,
  input  logic              out_free,
  output logic              in_tready,
  output logic              done,
  output npc_pkg::npc_ctl_t ctl
);
  import npc_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             query_acc;

  assign query_acc = in_tvalid && in_tready && (in_func == FUNC_QUERY);

  // Next state and address counter.
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          state_nxt = ST_SEARCH;
          addr_nxt  = IDX_W'(1);
        end
      end
      ST_SEARCH: begin
        if (addr_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!dp_busy && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready  = 1'b0;
    done       = 1'b0;
    ctl.start  = query_acc;
    ctl.rd_en  = 1'b0;
    ctl.rd_idx = addr_r;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_SEARCH: ctl.rd_en = 1'b1;
      ST_DRAIN:  done = !dp_busy && out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

/* design/nearest_palette_color_unit.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_unit
// Palette store with a nearest color search by squared Euclidean distance.
//
//   Channel  Group    Payload
//   -------  -------  -------------------------------------------------------
//   input    in_*     tuser: func; tdata: entry_index, red, green, blue
//   result   out_*    tdata: color_index, best_distance (query items only)
//
// A palette write gives no result.
// A query reads entries 1 to PALETTE_SIZE-1 one per cycle through the single
// RAM read port, then drains a three-stage pipeline; in_tready stays low until
// the result is loaded into the output register, so no new item is taken
// while a query is in progress.
// Reset clears only control; palette entries are undefined until written.
// A result waiting in the output register does not block the next transfer;
// only the end of the following query waits for it to be taken.
// ----------------------------------------------------------------------------
module nearest_palette_color_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [0:0]  in_tuser,   // func[0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // color_index[7:0], best_distance[25:8], zero[31:26]
);
  import npc_pkg::*;

  func_t              in_func;
  logic [IDX_W-1:0]   in_entry_index;
  logic [COLOR_W-1:0] in_color;
  logic               wr_en;
  logic [COLOR_W-1:0] rd_data;
  logic               dp_busy;
  logic               done;
  logic               out_free;
  npc_ctl_t           ctl;
  logic [IDX_W-1:0]   best_idx;
  logic [DIST_W-1:0]  best_dist;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  // Unpack the input transfer; the store keeps red in the top byte.
  assign in_func        = func_t'(in_tuser[0]);
  assign in_entry_index = in_tdata[7:0];
  assign in_color       = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
  assign wr_en          = in_tvalid && in_tready && (in_func == FUNC_WRITE);

  npc_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_entry_index),
    .wr_data (in_color),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_idx),
    .rd_data (rd_data)
  );

  npc_search_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_func),
    .dp_busy   (dp_busy),
    .out_free  (out_free),
    .in_tready (in_tready),
    .done      (done),
    .ctl       (ctl)
  );

  npc_dist_min u_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .query_color (in_color),
    .rd_data     (rd_data),
    .busy        (dp_busy),
    .best_idx    (best_idx),
    .best_dist   (best_dist)
  );

  // Output register.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= {6'b0, best_dist, best_idx};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/npc_checker.sv */
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks for the nearest palette color unit.
// ----------------------------------------------------------------------------
module npc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import npc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A query transfer is followed by a closed input.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == FUNC_QUERY) |=> !in_tready)
    else $error("input taken during a search");

  // The index lies within the searched range.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] != 8'd0) && (out_tdata[7:0] <= LAST_IDX))
    else $error("result index outside searched range");

  // The distance is bounded and the padding is zero.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[25:8] <= DIST_MAX) && (out_tdata[31:26] == 6'd0))
    else $error("result distance out of range");

endmodule

bind nearest_palette_color_unit npc_checker u_npc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
